// ===== sv/atrtw_pkg.sv =====
// Shared types and constants for the AT final-result detector.
`timescale 1ns / 1ps
`default_nettype none

package atrtw_pkg;

   localparam int WindowBytes = 10;
   localparam int MaxExpected = 8;
   localparam int ExpLenWidth = 4;
   localparam int CountWidth  = 16;
   localparam int CapWidth    = 17;
   localparam int AddrWidth   = 6;
   localparam int DataWidth   = 64;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_ERROR   = 2'd1;
   localparam logic [1:0] RES_TIMEOUT = 2'd2;

   localparam logic [2:0] REG_PATTERN  = 3'd0;
   localparam logic [2:0] REG_LENGTH   = 3'd1;
   localparam logic [2:0] REG_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_GRACE    = 3'd3;
   localparam logic [2:0] REG_CAPACITY = 3'd4;

   localparam logic [CapWidth-1:0] CapLimit = 17'd65536;

   // Element 0 holds the last character of each text.
   localparam logic [5:0][7:0] PatOk  = {8'h0D, 8'h0A, "O", "K", 8'h0D, 8'h0A};
   localparam logic [8:0][7:0] PatErr = {8'h0D, 8'h0A, "E", "R", "R", "O", "R",
                                         8'h0D, 8'h0A};
   localparam logic [9:0][7:0] PatCme = {"+", "C", "M", "E", " ", "E", "R", "R",
                                         "O", "R"};
   localparam logic [9:0][7:0] PatCms = {"+", "C", "M", "S", " ", "E", "R", "R",
                                         "O", "R"};

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0]            result_code;
      logic [CountWidth-1:0] stored_bytes;
   } rsp_type;

   typedef struct packed {
      logic ok;
      logic err;
      logic exp;
   } hit_type;

   typedef logic [WindowBytes-1:0][7:0] window_type;

endpackage

`default_nettype wire

// ===== sv/atrtw_match.sv =====
// Terminator and expected-text matcher over the receive window.
`timescale 1ns / 1ps
`default_nettype none

module atrtw_match
   import atrtw_pkg::*;
(
   input  window_type                  window,
   input  logic [MaxExpected*8-1:0]    exp_pattern,
   input  logic [ExpLenWidth-1:0]      exp_length,
   output hit_type                     hits
);

   logic [MaxExpected-1:0][7:0] exp_bytes;
   logic [ExpLenWidth-1:0]      lim_len;
   logic [ExpLenWidth-1:0]      eff_len;
   logic [MaxExpected:0]        len_match;
   logic                        ok_hit;
   logic                        err_hit;
   logic                        cme_hit;
   logic                        cms_hit;

   assign exp_bytes = exp_pattern;
   assign lim_len   = (exp_length > ExpLenWidth'(MaxExpected)) ?
                      ExpLenWidth'(MaxExpected) : exp_length;

   always_comb begin
      eff_len = lim_len;
      for (int i = MaxExpected - 1; i >= 0; i--) begin
         if ((ExpLenWidth'(i) < lim_len) && (exp_bytes[i] == 8'd0)) begin
            eff_len = ExpLenWidth'(i);
         end
      end
   end

   always_comb begin
      len_match = '0;
      for (int l = 1; l <= MaxExpected; l++) begin
         len_match[l] = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (window[k] != exp_bytes[l-1-k]) begin
               len_match[l] = 1'b0;
            end
         end
      end
   end

   assign ok_hit  = (window[5:0] == PatOk);
   assign err_hit = (window[8:0] == PatErr);
   assign cme_hit = (window[9:0] == PatCme);
   assign cms_hit = (window[9:0] == PatCms);

   assign hits.ok  = ok_hit;
   assign hits.err = err_hit | cme_hit | cms_hit;
   assign hits.exp = (eff_len != '0) && len_match[eff_len];

endmodule

`default_nettype wire

// ===== sv/at_response_terminator_wait.sv =====
// Top level of the AT final-result detector: control, timers, registers, output queue.
//
//   channel   ports              payload     direction
//   request   req_valid/stall    req_type    in
//   response  rsp_valid/stall    rsp_type    out
//   config    psel..pready       64-bit      APB
//
// One request is taken every cycle while req_stall is low; its effect on state lands
// at the same edge. A response is registered in the output or, if stalled, skid slot.
// Two response slots: req_stall rises only while both are full.
// Synchronous reset restores register defaults and returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module at_response_terminator_wait
   import atrtw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_GRACE
   } phase_type;

   logic [DataWidth-1:0]   pattern_ff;
   logic [ExpLenWidth-1:0] exp_len_ff;
   logic [31:0]            timeout_ff;
   logic [15:0]            grace_ff;
   logic [CapWidth-1:0]    cap_ff;

   phase_type              phase_ff, phase_in;
   window_type             window_ff, window_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   hit_type                flags_ff, flags_in;
   logic                   frozen_ff, frozen_in;
   logic [31:0]            elapsed_ff, elapsed_in;

   logic                   out_v_ff, skid_v_ff;
   rsp_type                out_ff, skid_ff;

   window_type             win_shift;
   hit_type                hits;
   hit_type                flags_new;
   logic [CapWidth-1:0]    cap_sat;
   logic [CapWidth-1:0]    count_next;
   logic [31:0]            elapsed_inc;
   logic                   accept;
   logic                   push;
   logic                   pop;
   logic                   succ;
   rsp_type                result;
   logic                   wr_en;

   assign accept      = req_valid & ~req_stall;
   assign req_stall   = skid_v_ff;
   assign pop         = out_v_ff & ~rsp_stall;
   assign rsp_valid   = out_v_ff;
   assign rsp_data    = out_ff;
   assign pready      = 1'b1;
   assign wr_en       = psel & penable & pwrite;

   assign win_shift   = {window_ff[WindowBytes-2:0], req_data.byte_value};
   assign cap_sat     = (cap_ff > CapLimit) ? CapLimit : cap_ff;
   assign count_next  = {1'b0, count_ff} + CapWidth'(1);
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;

   atrtw_match u_match (
      .window      (win_shift),
      .exp_pattern (pattern_ff),
      .exp_length  (exp_len_ff),
      .hits        (hits)
   );

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      flags_in   = flags_ff;
      frozen_in  = frozen_ff;
      elapsed_in = elapsed_ff;
      flags_new  = flags_ff;
      succ       = 1'b0;
      push       = 1'b0;
      result     = '{result_code: RES_OK, stored_bytes: count_ff};
      if (accept) begin
         case (req_data.operation)
            OP_START: begin
               phase_in   = PH_WAIT;
               window_in  = '0;
               count_in   = '0;
               flags_in   = '0;
               frozen_in  = 1'b0;
               elapsed_in = '0;
            end
            OP_BYTE: begin
               if (phase_ff != PH_IDLE) begin
                  if (count_next < cap_sat) begin
                     count_in = count_next[CountWidth-1:0];
                     if (!frozen_ff) begin
                        if (req_data.byte_value == 8'd0) begin
                           frozen_in = 1'b1;
                        end else begin
                           window_in = win_shift;
                           flags_new = flags_ff | hits;
                        end
                     end
                  end
                  flags_in            = flags_new;
                  result.stored_bytes = count_in;
                  if (phase_ff == PH_WAIT) begin
                     succ = (exp_len_ff != '0) ? flags_new.exp : flags_new.ok;
                     if (succ) begin
                        if ((exp_len_ff == '0) || (grace_ff == '0) ||
                            flags_new.ok || flags_new.err) begin
                           push     = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in   = PH_GRACE;
                           elapsed_in = '0;
                        end
                     end else if (flags_new.err) begin
                        push               = 1'b1;
                        result.result_code = RES_ERROR;
                        phase_in           = PH_IDLE;
                     end
                  end else if (flags_new.ok || flags_new.err) begin
                     push     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  elapsed_in = elapsed_inc;
                  if (phase_ff == PH_WAIT) begin
                     if (elapsed_inc >= timeout_ff) begin
                        push               = 1'b1;
                        result.result_code = RES_TIMEOUT;
                        phase_in           = PH_IDLE;
                     end
                  end else if (elapsed_inc >= {16'd0, grace_ff}) begin
                     push     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         window_ff  <= '0;
         count_ff   <= '0;
         flags_ff   <= '0;
         frozen_ff  <= 1'b0;
         elapsed_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         count_ff   <= count_in;
         flags_ff   <= flags_in;
         frozen_ff  <= frozen_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Hold a response in the skid slot while the output slot is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= push;
         end else begin
            out_v_ff  <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= result;
         end else begin
            out_ff  <= result;
         end
      end else if (push) begin
         skid_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         exp_len_ff <= '0;
         timeout_ff <= 32'd1000;
         grace_ff   <= 16'd200;
         cap_ff     <= 17'd256;
      end else if (wr_en) begin
         unique case (paddr[5:3])
            REG_PATTERN:  pattern_ff <= pwdata;
            REG_LENGTH:   exp_len_ff <= pwdata[ExpLenWidth-1:0];
            REG_TIMEOUT:  timeout_ff <= pwdata[31:0];
            REG_GRACE:    grace_ff   <= pwdata[15:0];
            REG_CAPACITY: cap_ff     <= pwdata[CapWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         REG_PATTERN:  prdata = pattern_ff;
         REG_LENGTH:   prdata = {{(DataWidth-ExpLenWidth){1'b0}}, exp_len_ff};
         REG_TIMEOUT:  prdata = {32'd0, timeout_ff};
         REG_GRACE:    prdata = {48'd0, grace_ff};
         REG_CAPACITY: prdata = {{(DataWidth-CapWidth){1'b0}}, cap_ff};
         default:      prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the AT final-result detector: a scripted opening and random command waits.
`timescale 1ns / 1ps

module tb;
   import atrtw_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int unsigned HoldCycles = 60;
   localparam int unsigned RandomRequests = 1250;
   localparam int PhaseCount = 12;

   localparam logic [79:0] OK_TEXT  = "\015\012OK\015\012";
   localparam logic [79:0] ERR_TEXT = "\015\012ERROR\015\012";
   localparam logic [79:0] CME_TEXT = "+CME ERROR";
   localparam logic [79:0] CMS_TEXT = "+CMS ERROR";

   typedef enum logic [1:0] {IDLE, ANSWER, GRACE} wait_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  value;
      logic        typed;
      logic [1:0]  code;
      logic [15:0] count;
   } script_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [AddrWidth-1:0] paddr;
   logic [DataWidth-1:0] pwdata;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   // register copies
   logic [63:0] cfg_pattern;
   logic [3:0]  cfg_length;
   logic [31:0] cfg_timeout;
   logic [15:0] cfg_grace;
   logic [16:0] cfg_capacity;

   // detector state
   wait_state_type state;
   logic [79:0] recent;
   int unsigned held;
   bit          seen_ok;
   bit          seen_err;
   bit          seen_exp;
   bit          frozen;
   logic [31:0] ticks;

   rsp_type     pending_rsp[$];
   logic [7:0]  burst[$];
   int unsigned work_items;
   int unsigned sent_items;
   int unsigned checked;
   int unsigned mismatches;
   int unsigned settings;
   int unsigned send_gap_pct;
   int unsigned stall_pct;
   bit          hold_pending;

   script_row_type opening [0:20] = '{
      {OP_TICK,    8'h00, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'hFF, 1'b0, RES_OK,    16'd0},
      {OP_IGNORED, 8'hFF, 1'b0, RES_OK,    16'd0},
      {OP_START,   8'h00, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0D, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0A, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    "O",   1'b0, RES_OK,    16'd0},
      {OP_BYTE,    "K",   1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0D, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0A, 1'b1, RES_OK,    16'd6},
      {OP_START,   8'hFF, 1'b0, RES_OK,    16'd0},
      {OP_START,   8'h00, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0D, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0A, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    "E",   1'b0, RES_OK,    16'd0},
      {OP_BYTE,    "R",   1'b0, RES_OK,    16'd0},
      {OP_BYTE,    "R",   1'b0, RES_OK,    16'd0},
      {OP_BYTE,    "O",   1'b0, RES_OK,    16'd0},
      {OP_BYTE,    "R",   1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0D, 1'b0, RES_OK,    16'd0},
      {OP_BYTE,    8'h0A, 1'b1, RES_ERROR, 16'd9}
   };

   at_response_terminator_wait uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned expected_size();
      int unsigned n;
      n = (cfg_length > 4'd8) ? 8 : cfg_length;
      for (int unsigned i = 0; i < n; i++)
         if (cfg_pattern[8*i +: 8] == 8'h00) n = i;
      return n;
   endfunction

   function automatic bit tail_is(input logic [79:0] text, input int unsigned len);
      if (len == 0 || held < len) return 1'b0;
      for (int unsigned k = 0; k < len; k++)
         if (recent[8*k +: 8] != text[8*k +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      logic [79:0] exp_text;
      int unsigned n;
      recent = {recent[71:0], b};
      exp_text = '0;
      n = expected_size();
      for (int unsigned k = 0; k < n; k++)
         exp_text[8*k +: 8] = cfg_pattern[8*(n-1-k) +: 8];
      if (tail_is(OK_TEXT, 6)) seen_ok = 1'b1;
      if (tail_is(ERR_TEXT, 9) || tail_is(CME_TEXT, 10) || tail_is(CMS_TEXT, 10))
         seen_err = 1'b1;
      if (tail_is(exp_text, n)) seen_exp = 1'b1;
   endfunction

   function automatic bit close_wait(input logic [1:0] code, output rsp_type r);
      r.result_code = code;
      r.stored_bytes = held[15:0];
      state = IDLE;
      return 1'b1;
   endfunction

   function automatic bit detector_step(input logic [1:0] op, input logic [7:0] b,
                                        output rsp_type r);
      int unsigned cap;
      bit win;
      r = '0;
      if (op == OP_START) begin
         recent = '0;
         held = 0;
         seen_ok = 1'b0;
         seen_err = 1'b0;
         seen_exp = 1'b0;
         frozen = 1'b0;
         ticks = '0;
         state = ANSWER;
         return 1'b0;
      end
      if (state == IDLE || op == OP_IGNORED) return 1'b0;
      if (op == OP_BYTE) begin
         cap = (cfg_capacity > 17'd65536) ? 65536 : cfg_capacity;
         if (held + 1 < cap) begin
            held++;
            if (!frozen) begin
               if (b == 8'h00) frozen = 1'b1;
               else scan_byte(b);
            end
         end
         if (state == ANSWER) begin
            win = (cfg_length != 4'd0) ? seen_exp : seen_ok;
            if (win && (cfg_length == 4'd0 || cfg_grace == 16'd0 || seen_ok || seen_err))
               return close_wait(RES_OK, r);
            if (win) begin
               state = GRACE;
               ticks = '0;
               return 1'b0;
            end
            if (seen_err) return close_wait(RES_ERROR, r);
            return 1'b0;
         end
         if (seen_ok || seen_err) return close_wait(RES_OK, r);
         return 1'b0;
      end
      if (ticks != 32'hFFFF_FFFF) ticks++;
      if (state == ANSWER) begin
         if (ticks >= cfg_timeout) return close_wait(RES_TIMEOUT, r);
         return 1'b0;
      end
      if (ticks >= {16'd0, cfg_grace}) return close_wait(RES_OK, r);
      return 1'b0;
   endfunction

   function automatic logic [63:0] as_pattern(input logic [63:0] s, input int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++)
         v[8*i +: 8] = s[8*(n-1-i) +: 8];
      return v;
   endfunction

   function automatic void add_text(input logic [127:0] t, input int n);
      for (int i = n - 1; i >= 0; i--)
         burst.push_back(t[8*i +: 8]);
   endfunction

   function automatic void add_noise(input int unsigned n);
      repeat (n)
         burst.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(32, 126)));
   endfunction

   task automatic push_request(input logic [1:0] op, input logic [7:0] b, input bit typed,
                               input rsp_type typed_rsp);
      rsp_type r;
      bit got;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.operation = op;
      req_data.byte_value = b;
      do @(posedge clock); while (req_stall);
      sent_items++;
      if (op == OP_START || (state != IDLE && op != OP_IGNORED)) work_items++;
      got = detector_step(op, b, r);
      if (typed) pending_rsp.push_back(typed_rsp);
      else if (got) pending_rsp.push_back(r);
   endtask

   task automatic offer(input logic [1:0] op, input logic [7:0] b);
      push_request(op, b, 1'b0, '0);
   endtask

   task automatic send_burst(input int unsigned tick_pct);
      foreach (burst[i]) begin
         if ($urandom_range(0, 99) < tick_pct) offer(OP_TICK, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 199) == 0) offer(OP_IGNORED, 8'($urandom_range(0, 255)));
         offer(OP_BYTE, burst[i]);
      end
      burst.delete();
   endtask

   task automatic run_command();
      int unsigned kind;
      int unsigned n;
      offer(OP_START, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0) offer(OP_START, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) add_text("AT+CSQ\015", 7);
      add_noise($urandom_range(0, 6));
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            if ($urandom_range(0, 1) == 1) add_text("\015\012+CSQ: 20,0\015\012", 14);
            add_text(OK_TEXT, 6);
         end
         3: add_text(ERR_TEXT, 9);
         4: add_text("+CME ERROR: 10\015\012", 16);
         5: add_text("+CMS ERROR: 50\015\012", 16);
         6: begin
            n = expected_size();
            for (int unsigned i = 0; i < n; i++)
               burst.push_back(cfg_pattern[8*i +: 8]);
            add_noise($urandom_range(0, 3));
            case ($urandom_range(0, 2))
               0: add_text(OK_TEXT, 6);
               1: add_text(ERR_TEXT, 9);
               default: ;
            endcase
         end
         7: begin
            add_noise($urandom_range(0, 3));
            burst.push_back(8'h00);
            add_text(OK_TEXT, 6);
         end
         8: begin
            add_noise($urandom_range(50, 80));
            add_text(OK_TEXT, 6);
         end
         default: add_text("\015\012ERRO", 6);
      endcase
      send_burst($urandom_range(0, 15));
      for (n = 0; state != IDLE && n < 150; n++)
         offer(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 3'b000};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_PATTERN:  cfg_pattern = value;
         REG_LENGTH:   cfg_length = value[3:0];
         REG_TIMEOUT:  cfg_timeout = value[31:0];
         REG_GRACE:    cfg_grace = value[15:0];
         REG_CAPACITY: cfg_capacity = value[16:0];
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stall, or a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall = 1'b1;
            repeat (HoldCycles) @(negedge clock);
         end
         rsp_stall = ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: code %0d bytes %0d",
                           rsp_data.result_code, rsp_data.stored_bytes);
            end else begin
               want = pending_rsp.pop_front();
               checked++;
               if (rsp_data.result_code !== want.result_code ||
                   rsp_data.stored_bytes !== want.stored_bytes) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"response %0d: expected code %0d bytes %0d, ",
                               "got code %0d bytes %0d"},
                              checked, want.result_code, want.stored_bytes,
                              rsp_data.result_code, rsp_data.stored_bytes);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("at_response_terminator_wait verification failed");
      $finish;
   end

   initial begin
      logic [63:0] pat;
      logic [3:0]  len;
      logic [31:0] tmo;
      logic [15:0] grc;
      logic [16:0] cap;
      int unsigned base;
      int unsigned goal;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_pending = 1'b0;
      send_gap_pct = 22;
      stall_pct = 68;
      cfg_pattern = '0;
      cfg_length = '0;
      cfg_timeout = 32'd1000;
      cfg_grace = 16'd200;
      cfg_capacity = 17'd256;
      state = IDLE;
      recent = '0;
      held = 0;
      seen_ok = 1'b0;
      seen_err = 1'b0;
      seen_exp = 1'b0;
      frozen = 1'b0;
      ticks = '0;
      work_items = 0;
      sent_items = 0;
      checked = 0;
      mismatches = 0;
      settings = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (opening[i])
         push_request(opening[i].op, opening[i].value, opening[i].typed,
                      {opening[i].code, opening[i].count});

      base = work_items;
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: begin
               pat = as_pattern("CONNECT", 7); len = 4'd0; tmo = 32'd20;
               grc = 16'd5; cap = 17'd64;
            end
            1: begin
               pat = as_pattern("> ", 2); len = 4'd2; tmo = 32'd0;
               grc = 16'd0; cap = 17'd0;
            end
            2: begin
               pat = '1; len = 4'd15; tmo = 32'd30;
               grc = 16'hFFFF; cap = 17'd65536;
            end
            3: begin
               pat = '0; len = 4'd8; tmo = 32'hFFFF_FFFF;
               grc = 16'd10; cap = 17'h1FFFF;
            end
            4: begin
               pat = as_pattern("AB\000CD", 5); len = 4'd5; tmo = 32'd25;
               grc = 16'd3; cap = 17'd1;
            end
            5: begin
               pat = as_pattern("ERROR\015\012", 7); len = 4'd7; tmo = 32'd40;
               grc = 16'd8; cap = 17'd65537;
            end
            6: begin
               pat = as_pattern("CONNECT", 7); len = 4'd7; tmo = 32'd40;
               grc = 16'd12; cap = 17'd100;
            end
            default: begin
               pat = {$urandom(), $urandom()};
               len = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
               tmo = $urandom_range(1, 60);
               grc = 16'($urandom_range(0, 20));
               cap = 17'($urandom_range(64, 300));
            end
         endcase
         settle();
         csr_write(REG_PATTERN, pat);
         csr_write(REG_LENGTH, {60'd0, len});
         csr_write(REG_TIMEOUT, {32'd0, tmo});
         csr_write(REG_GRACE, {48'd0, grc});
         csr_write(REG_CAPACITY, {47'd0, cap});
         settings++;

         // hold the receiver off while back-to-back answers fill the block
         if (p == 0) begin
            hold_pending = 1'b1;
            send_gap_pct = 0;
            repeat (6) begin
               offer(OP_START, 8'h00);
               add_text(OK_TEXT, 6);
               send_burst(0);
            end
            settle();
         end

         goal = base + (p + 1) * RandomRequests / PhaseCount;
         while (work_items < goal) begin
            if (work_items - base < RandomRequests / 3) begin
               send_gap_pct = 22;
               stall_pct = 68;
            end else if (work_items - base < 2 * RandomRequests / 3) begin
               send_gap_pct = 68;
               stall_pct = 22;
            end else begin
               send_gap_pct = 0;
               stall_pct = 0;
            end
            run_command();
         end
      end

      settle();
      $display("covered %0d requests (%0d acted on) across %0d register settings",
               sent_items, work_items, settings);
      $display("%0d responses checked, %0d mismatches", checked, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("at_response_terminator_wait verification clean");
      else
         $display("at_response_terminator_wait verification failed");
      $finish;
   end

endmodule

// ===== at_response_terminator_wait.f =====
sv/atrtw_pkg.sv
sv/atrtw_match.sv
sv/at_response_terminator_wait.sv
test/tb.sv
